// File: rtl/mjt_pkg.sv
// Shared types, constants and helpers for the minimum-jerk trajectory core.
// No dependencies.
`default_nettype none

package mjt_pkg;

  localparam int MAX_WAYPOINTS_DEF = 16;
  localparam int NUM_AXES_DEF      = 6;

  // Wide enough to hold any waypoint count up to 256.
  localparam int CNT_W = 9;

  // Serial divider geometry.
  localparam int DVD_W = 48;
  localparam int DVS_W = 32;

  localparam logic [15:0] DURATION_RESET = 16'd1000;
  localparam logic [4:0]  COUNT_RESET    = 5'd2;

  // Register index codes (address bit 2).
  localparam logic REG_DURATION = 1'b0;
  localparam logic REG_COUNT    = 1'b1;

  // Item opcodes.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [15:0] duration;
    logic [4:0]  count;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TAU,
    ST_TAU_WAIT,
    ST_POW_MUL,
    ST_POW_ACC,
    ST_POLY,
    ST_RD0,
    ST_RD1,
    ST_ALPHA,
    ST_MULP,
    ST_POS,
    ST_VPREP,
    ST_VDIV,
    ST_VWAIT,
    ST_APREP,
    ST_ADIV,
    ST_AWAIT,
    ST_RDH,
    ST_CAPH,
    ST_EMIT
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mjt_if.sv
// Valid/ready channel interfaces for item beats and result beats.
// Depends on nothing.
`default_nettype none

interface mjt_req_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] time_stamp;
  logic [3:0]  waypoint_number;
  logic [2:0]  axis_number;
  logic signed [31:0] waypoint_value;

  modport source (output valid, op, time_stamp, waypoint_number, axis_number,
                  waypoint_value, input ready);
  modport sink   (input valid, op, time_stamp, waypoint_number, axis_number,
                  waypoint_value, output ready);
endinterface

interface mjt_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  axis;
  logic signed [31:0] position;
  logic signed [31:0] velocity;
  logic signed [31:0] acceleration;
  logic [3:0]  segment;
  logic        finished;
  logic        last;

  modport source (output valid, axis, position, velocity, acceleration, segment,
                  finished, last, input ready);
  modport sink   (input valid, axis, position, velocity, acceleration, segment,
                  finished, last, output ready);
endinterface

`default_nettype wire

// File: rtl/min_jerk_waypoint_trajectory_core.sv
// Minimum-jerk waypoint trajectory core: sequencer, shared multiplier, store and divider.
// Depends on mjt_pkg, mjt_if, mjt_store, mjt_div, mjt_cfg.
`default_nettype none

// Load beats write one waypoint word (waypoint x axis) into a one-port-read
// memory and restart the path at segment 0; the next beat may follow a load
// at once. Tick beats produce NUM_AXES result beats, one per axis, lowest
// axis first, last set on the highest. Within a segment the cost of a tick
// (plus any result stall) is set by the 48-step serial divider, used once
// for tau = elapsed/duration and twice per axis for the velocity and
// acceleration scaling. The powers of tau and the alpha products run
// through one shared 33x25 multiplier with a register behind it. A tick
// that advances the segment or holds the final waypoint runs, per axis,
// one memory read and its capture before the result beat. Waypoint words
// read before they are written return whatever the memory holds; there is no
// clearing pass. Registers: duration_ticks at byte 0, waypoint_count at 4;
// write them only while no tick is in progress.
module min_jerk_waypoint_trajectory_core #(
  parameter int MAX_WAYPOINTS = mjt_pkg::MAX_WAYPOINTS_DEF,
  parameter int NUM_AXES      = mjt_pkg::NUM_AXES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  mjt_req_if.sink          req,
  mjt_rsp_if.source        rsp
);

  localparam int DEPTH = MAX_WAYPOINTS * NUM_AXES;
  localparam int AW    = $clog2(DEPTH);
  localparam int SEG_W = $clog2(MAX_WAYPOINTS);
  localparam int CW    = mjt_pkg::CNT_W;
  localparam int DVD_W = mjt_pkg::DVD_W;
  localparam int DVS_W = mjt_pkg::DVS_W;

  mjt_pkg::cfg_t   cfg;
  mjt_pkg::state_t state, state_next;

  // ---------------- configuration ----------------
  mjt_cfg u_cfg (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  // duration 0 acts as 1; count clamped to 1..MAX_WAYPOINTS
  logic [15:0]   d16;
  logic [CW-1:0] cnt_ext;
  logic [CW-1:0] nn;
  logic [CW-1:0] nn_m1;

  assign d16     = (cfg.duration == 16'd0) ? 16'd1 : cfg.duration;
  assign cnt_ext = {{(CW-5){1'b0}}, cfg.count};
  assign nn      = (cnt_ext == '0) ? CW'(1) :
                   (cnt_ext > CW'(MAX_WAYPOINTS)) ? CW'(MAX_WAYPOINTS) : cnt_ext;
  assign nn_m1   = nn - CW'(1);

  // ---------------- control state ----------------
  logic [SEG_W-1:0] seg;
  logic             restart;
  logic [31:0]      start_time;
  logic             done;

  logic req_fire, rsp_fire;
  assign req_fire = req.valid && req.ready;
  assign rsp_fire = rsp.valid && rsp.ready;

  // tick decision, evaluated on the accepting edge
  logic [31:0]   st_eff;
  logic [31:0]   elapsed;
  logic [CW-1:0] seg_p1_cnt;
  logic          can_move;
  logic          moving;
  logic [SEG_W-1:0] seg_p1;

  assign st_eff     = restart ? req.time_stamp : start_time;
  assign elapsed    = req.time_stamp - st_eff;
  assign seg_p1_cnt = CW'(seg) + CW'(1);
  assign can_move   = seg_p1_cnt < nn;
  assign moving     = can_move && (elapsed <= {16'b0, d16});
  assign seg_p1     = seg + SEG_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      seg        <= '0;
      restart    <= 1'b1;
      start_time <= '0;
      done       <= 1'b0;
    end else if (req_fire) begin
      if (req.op == mjt_pkg::OP_LOAD) begin
        seg     <= '0;
        restart <= 1'b1;
        done    <= 1'b0;
      end else begin
        start_time <= st_eff;
        restart    <= 1'b0;
        if (can_move && !moving) begin
          // segment ran out: step to the next waypoint
          seg     <= seg_p1;
          restart <= 1'b1;
        end else if (!can_move) begin
          done <= 1'b1;
        end
      end
    end
  end

  // ---------------- waypoint store ----------------
  logic [AW-1:0]    raddr, waddr;
  logic [31:0]      rdata;
  logic             we;
  logic [SEG_W-1:0] rd_wp;   // waypoint read on advance/hold
  logic [SEG_W-1:0] rd_sel;
  logic [2:0]       ax;
  logic [31:0]      raddr_full, waddr_full;

  always_comb begin
    case (state)
      mjt_pkg::ST_RD1: rd_sel = seg_p1;
      mjt_pkg::ST_RDH: rd_sel = rd_wp;
      default:         rd_sel = seg;
    endcase
  end

  assign raddr_full = 32'(rd_sel) * 32'(NUM_AXES) + 32'(ax);
  assign raddr      = raddr_full[AW-1:0];
  assign waddr_full = 32'(req.waypoint_number) * 32'(NUM_AXES) + 32'(req.axis_number);
  assign waddr      = waddr_full[AW-1:0];
  assign we = req_fire && (req.op == mjt_pkg::OP_LOAD)
              && (CW'(req.waypoint_number) < CW'(MAX_WAYPOINTS))
              && ({1'b0, req.axis_number} < 4'(NUM_AXES));

  mjt_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk, .we, .waddr, .wdata(req.waypoint_value), .raddr, .rdata
  );

  // ---------------- divider ----------------
  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs;

  assign div_start = (state == mjt_pkg::ST_TAU) || (state == mjt_pkg::ST_VDIV)
                     || (state == mjt_pkg::ST_ADIV);

  mjt_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk, .rst, .start(div_start), .dividend(div_dvd), .divisor(div_dvs),
    .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  // ---------------- shared multiplier ----------------
  logic               moving_r;
  logic [16:0]        tau, pcur, p2, p3, p4, p5;
  logic [1:0]         k;
  logic [31:0]        dd;
  logic signed [24:0] sv, vv, av;
  logic signed [32:0] alpha;
  logic [31:0]        w0_r;
  logic signed [57:0] prod;
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic               neg_r;
  logic [31:0]        pos_r, vel_r, acc_r;

  always_comb begin
    case (state)
      mjt_pkg::ST_POW_MUL: begin
        mul_a = $signed({16'b0, pcur});
        mul_b = $signed({8'b0, tau});
      end
      mjt_pkg::ST_MULP: begin
        mul_a = alpha;
        mul_b = sv;
      end
      mjt_pkg::ST_POS: begin
        mul_a = alpha;
        mul_b = vv;
      end
      default: begin
        mul_a = alpha;
        mul_b = av;
      end
    endcase
  end

  // Q1.16 power step: round(x*tau / 2^16)
  logic [33:0] qm_sum;
  logic [16:0] qm;
  assign qm_sum = prod[33:0] + 34'd32768;
  assign qm     = qm_sum[32:16];

  // blend polynomials
  logic signed [26:0] s27, v27, a27;
  assign s27 = $signed({10'b0, p3}) * 27'sd10 - $signed({10'b0, p4}) * 27'sd15
             + $signed({10'b0, p5}) * 27'sd6;
  assign v27 = $signed({10'b0, p2}) * 27'sd30 - $signed({10'b0, p3}) * 27'sd60
             + $signed({10'b0, p4}) * 27'sd30;
  assign a27 = $signed({10'b0, tau}) * 27'sd60 - $signed({10'b0, p2}) * 27'sd180
             + $signed({10'b0, p3}) * 27'sd120;

  // position: w0 + floor((alpha*s + 2^15) / 2^16)
  logic signed [57:0] rnd, sh;
  logic signed [63:0] pos64;
  assign rnd   = prod + 58'sd32768;
  assign sh    = rnd >>> 16;
  assign pos64 = $signed({{6{sh[57]}}, sh}) + $signed({{32{w0_r[31]}}, w0_r});

  // |alpha*x| plus half the divisor, pre-shifted by 2^16
  logic [57:0] mag;
  logic [58:0] vsum, asum;
  assign mag  = prod[57] ? 58'(-prod) : 58'(prod);
  assign vsum = {1'b0, mag} + (59'(d16) << 15);
  assign asum = {1'b0, mag} + (59'(dd) << 15);

  // signed, saturated quotient
  logic [31:0] qsat;
  always_comb begin
    if (!neg_r) begin
      qsat = (div_q > DVD_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : div_q[31:0];
    end else begin
      qsat = (div_q > DVD_W'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-div_q[31:0]);
    end
  end

  logic ax_last;
  assign ax_last = (ax == 3'(NUM_AXES - 1));

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      mjt_pkg::ST_IDLE: begin
        ax <= '0;
        if (req_fire) begin
          moving_r <= moving;
          rd_wp    <= (can_move && !moving) ? seg_p1 : nn_m1[SEG_W-1:0];
          div_dvd  <= {elapsed, 16'b0};
          div_dvs  <= {16'b0, d16};
          dd       <= d16 * d16;
        end
      end
      mjt_pkg::ST_TAU_WAIT: begin
        if (div_done) begin
          tau  <= div_q[16:0];
          pcur <= div_q[16:0];
          k    <= '0;
        end
      end
      mjt_pkg::ST_POW_MUL: prod <= mul_a * mul_b;
      mjt_pkg::ST_POW_ACC: begin
        case (k)
          2'd0:    p2 <= qm;
          2'd1:    p3 <= qm;
          2'd2:    p4 <= qm;
          default: p5 <= qm;
        endcase
        pcur <= qm;
        k    <= k + 2'd1;
      end
      mjt_pkg::ST_POLY: begin
        sv <= s27[24:0];
        vv <= v27[24:0];
        av <= a27[24:0];
      end
      mjt_pkg::ST_RD1:   w0_r  <= rdata;
      mjt_pkg::ST_ALPHA: alpha <= $signed({rdata[31], rdata}) - $signed({w0_r[31], w0_r});
      mjt_pkg::ST_MULP:  prod  <= mul_a * mul_b;
      mjt_pkg::ST_POS: begin
        pos_r <= mjt_pkg::sat32(pos64);
        prod  <= mul_a * mul_b;
      end
      mjt_pkg::ST_VPREP: begin
        neg_r   <= prod[57];
        div_dvd <= {5'b0, vsum[58:16]};
        div_dvs <= {16'b0, d16};
        prod    <= mul_a * mul_b;
      end
      mjt_pkg::ST_VWAIT: if (div_done) vel_r <= qsat;
      mjt_pkg::ST_APREP: begin
        neg_r   <= prod[57];
        div_dvd <= {5'b0, asum[58:16]};
        div_dvs <= dd;
      end
      mjt_pkg::ST_AWAIT: if (div_done) acc_r <= qsat;
      mjt_pkg::ST_CAPH: begin
        pos_r <= rdata;
        vel_r <= '0;
        acc_r <= '0;
      end
      mjt_pkg::ST_EMIT: if (rsp_fire && !ax_last) ax <= ax + 3'd1;
      default: ;
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mjt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mjt_pkg::ST_IDLE: begin
        if (req_fire && req.op == mjt_pkg::OP_TICK) begin
          state_next = moving ? mjt_pkg::ST_TAU : mjt_pkg::ST_RDH;
        end
      end
      mjt_pkg::ST_TAU:      state_next = mjt_pkg::ST_TAU_WAIT;
      mjt_pkg::ST_TAU_WAIT: if (div_done) state_next = mjt_pkg::ST_POW_MUL;
      mjt_pkg::ST_POW_MUL:  state_next = mjt_pkg::ST_POW_ACC;
      mjt_pkg::ST_POW_ACC:  state_next = (k == 2'd3) ? mjt_pkg::ST_POLY : mjt_pkg::ST_POW_MUL;
      mjt_pkg::ST_POLY:     state_next = mjt_pkg::ST_RD0;
      mjt_pkg::ST_RD0:      state_next = mjt_pkg::ST_RD1;
      mjt_pkg::ST_RD1:      state_next = mjt_pkg::ST_ALPHA;
      mjt_pkg::ST_ALPHA:    state_next = mjt_pkg::ST_MULP;
      mjt_pkg::ST_MULP:     state_next = mjt_pkg::ST_POS;
      mjt_pkg::ST_POS:      state_next = mjt_pkg::ST_VPREP;
      mjt_pkg::ST_VPREP:    state_next = mjt_pkg::ST_VDIV;
      mjt_pkg::ST_VDIV:     state_next = mjt_pkg::ST_VWAIT;
      mjt_pkg::ST_VWAIT:    if (div_done) state_next = mjt_pkg::ST_APREP;
      mjt_pkg::ST_APREP:    state_next = mjt_pkg::ST_ADIV;
      mjt_pkg::ST_ADIV:     state_next = mjt_pkg::ST_AWAIT;
      mjt_pkg::ST_AWAIT:    if (div_done) state_next = mjt_pkg::ST_EMIT;
      mjt_pkg::ST_RDH:      state_next = mjt_pkg::ST_CAPH;
      mjt_pkg::ST_CAPH:     state_next = mjt_pkg::ST_EMIT;
      mjt_pkg::ST_EMIT: begin
        if (rsp_fire) begin
          if (ax_last) begin
            state_next = mjt_pkg::ST_IDLE;
          end else begin
            state_next = moving_r ? mjt_pkg::ST_RD0 : mjt_pkg::ST_RDH;
          end
        end
      end
      default: state_next = mjt_pkg::ST_IDLE;
    endcase
  end

  // ---------------- channel outputs ----------------
  logic [SEG_W+3:0] seg_wide;
  assign seg_wide = {4'b0, seg};

  assign req.ready        = (state == mjt_pkg::ST_IDLE);
  assign rsp.valid        = (state == mjt_pkg::ST_EMIT);
  assign rsp.axis         = ax;
  assign rsp.position     = pos_r;
  assign rsp.velocity     = vel_r;
  assign rsp.acceleration = acc_r;
  assign rsp.segment      = seg_wide[3:0];
  assign rsp.finished     = done;
  assign rsp.last         = ax_last;

`ifndef SYNTH
  // one item in flight: never take a beat while a result is pending
  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> !rsp.valid)
    else $error("item accepted while results pending");

  // the final axis beat frees the input side
  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.ready && rsp.last) |=> req.ready)
    else $error("input not ready after last result beat");

  // divider is never restarted mid-division
  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // a stalled result beat holds still
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.axis)
      && $stable(rsp.position) && $stable(rsp.velocity) && $stable(rsp.acceleration)))
    else $error("result beat changed while stalled");
`endif

endmodule

`default_nettype wire

// File: rtl/mjt_store.sv
// Waypoint memory: one write port, one read port, registered read data.
// Depends on nothing.
`default_nettype none

module mjt_store #(
  parameter int DEPTH = 96,
  parameter int AW    = 7
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/mjt_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`default_nettype none

module mjt_div #(
  parameter int DVD_W = 48,
  parameter int DVS_W = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DVD_W-1:0]      quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] acc;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             fits;

  assign trial = {rem, acc[DVD_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};
  assign quotient = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      acc <= {acc[DVD_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

// File: rtl/mjt_cfg.sv
// APB-style register file: segment duration and waypoint count.
// Depends on mjt_pkg.
`default_nettype none

module mjt_cfg (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output mjt_pkg::cfg_t    cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.duration <= mjt_pkg::DURATION_RESET;
      cfg.count    <= mjt_pkg::COUNT_RESET;
    end else if (wr) begin
      unique case (paddr[2])
        mjt_pkg::REG_DURATION: cfg.duration <= pwdata[15:0];
        mjt_pkg::REG_COUNT:    cfg.count    <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      mjt_pkg::REG_DURATION: prdata = {16'b0, cfg.duration};
      mjt_pkg::REG_COUNT:    prdata = {27'b0, cfg.count};
      default:               prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: dv/tb.sv
// Testbench for min_jerk_waypoint_trajectory_core: item beats in, one result beat per axis out.
// Depends on mjt_pkg, mjt_if and the core; predicts each tick and checks every result field.
`default_nettype none

module tb;

  localparam int NWP = mjt_pkg::MAX_WAYPOINTS_DEF;
  localparam int NAX = mjt_pkg::NUM_AXES_DEF;
  // This margin covers a load before a register write.
  localparam int LOAD_SETTLE = 16;
  localparam int TICK_CYCLES = 59 + 108 * NAX;

  typedef struct packed {
    logic        op;
    logic [31:0] time_stamp;
    logic [3:0]  waypoint_number;
    logic [2:0]  axis_number;
    logic [31:0] waypoint_value;
  } item_t;

  typedef struct packed {
    logic [2:0]  axis;
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] acceleration;
    logic [3:0]  segment;
    logic        finished;
    logic        last;
  } motion_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mjt_req_if req ();
  mjt_rsp_if rsp ();

  min_jerk_waypoint_trajectory_core u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req.sink),
    .rsp     (rsp.source)
  );

  // Shadow of the block's state and registers.
  logic signed [31:0] wp_mem [NWP][NAX];
  int unsigned        seg_idx;
  bit                 restart_pend;
  logic [31:0]        seg_t0;
  bit                 hold_done;
  int unsigned        dur_reg;
  int unsigned        cnt_reg;

  motion_t     motion_q[$];
  int          mismatch_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic [31:0] now_ts;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Rounded quotient, ties away from zero.
  function automatic longint div_near(input longint x, input longint d);
    longint m;
    longint q;
    m = (x < 0) ? -x : x;
    q = (m + d / 2) / d;
    return (x < 0) ? -q : q;
  endfunction

  function automatic longint qround(input longint a, input longint tau);
    return (a * tau + 32768) >>> 16;
  endfunction

  function automatic logic [31:0] clip32(input longint x);
    if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  // Update the shadow state for one accepted beat and queue the expected results.
  task automatic predict_beat(input item_t it);
    longint  d, n, el, tau, p2, p3, p4, p5, s, v, a, w0, alpha;
    longint  pos[NAX];
    longint  vel[NAX];
    longint  acc[NAX];
    motion_t m;
    if (it.op == mjt_pkg::OP_LOAD) begin
      if (it.waypoint_number < NWP && it.axis_number < NAX)
        wp_mem[it.waypoint_number][it.axis_number] = it.waypoint_value;
      seg_idx = 0;
      restart_pend = 1'b1;
      hold_done = 1'b0;
      return;
    end
    d = (dur_reg == 0) ? 1 : dur_reg;
    n = (cnt_reg < 1) ? 1 : (cnt_reg > NWP) ? NWP : cnt_reg;
    if (restart_pend) begin
      restart_pend = 1'b0;
      seg_t0 = it.time_stamp;
    end
    el = longint'(32'(it.time_stamp - seg_t0));
    if (seg_idx + 1 < n && el <= d) begin
      tau = (el << 16) / d;
      p2 = qround(tau, tau);
      p3 = qround(p2, tau);
      p4 = qround(p3, tau);
      p5 = qround(p4, tau);
      s = 10 * p3 - 15 * p4 + 6 * p5;
      v = 30 * p2 - 60 * p3 + 30 * p4;
      a = 60 * tau - 180 * p2 + 120 * p3;
      for (int i = 0; i < NAX; i++) begin
        w0 = wp_mem[seg_idx][i];
        alpha = longint'(wp_mem[seg_idx + 1][i]) - w0;
        pos[i] = w0 + ((alpha * s + 32768) >>> 16);
        vel[i] = div_near(alpha * v, d * 65536);
        acc[i] = div_near(alpha * a, d * d * 65536);
      end
    end else if (seg_idx + 1 < n) begin
      // segment ran out: step to the next waypoint and report it at rest
      restart_pend = 1'b1;
      seg_idx++;
      for (int i = 0; i < NAX; i++) begin
        pos[i] = wp_mem[seg_idx][i];
        vel[i] = 0;
        acc[i] = 0;
      end
    end else begin
      // past the final waypoint: hold it
      hold_done = 1'b1;
      for (int i = 0; i < NAX; i++) begin
        pos[i] = wp_mem[n - 1][i];
        vel[i] = 0;
        acc[i] = 0;
      end
    end
    for (int i = 0; i < NAX; i++) begin
      m.axis = 3'(i);
      m.position = clip32(pos[i]);
      m.velocity = clip32(vel[i]);
      m.acceleration = clip32(acc[i]);
      m.segment = seg_idx[3:0];
      m.finished = hold_done;
      m.last = (i == NAX - 1);
      motion_q.push_back(m);
    end
  endtask

  // Drive one beat at the falling edge, hold it until accepted.
  task automatic send_item(input item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      req.valid = 1'b0;
      repeat ($urandom_range(6)) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    req.valid = 1'b1;
    req.op = it.op;
    req.time_stamp = it.time_stamp;
    req.waypoint_number = it.waypoint_number;
    req.axis_number = it.axis_number;
    req.waypoint_value = it.waypoint_value;
    do @(posedge clk); while (!req.ready);
    predict_beat(it);
  endtask

  task automatic send_load(input int wn, input int ax, input logic [31:0] val);
    item_t it;
    it = '0;
    it.op = mjt_pkg::OP_LOAD;
    it.time_stamp = $urandom;
    it.waypoint_number = 4'(wn);
    it.axis_number = 3'(ax);
    it.waypoint_value = val;
    send_item(it);
  endtask

  task automatic send_tick(input logic [31:0] ts);
    item_t it;
    it = '0;
    it.op = mjt_pkg::OP_TICK;
    it.time_stamp = ts;
    it.waypoint_number = 4'($urandom);
    it.axis_number = 3'($urandom);
    it.waypoint_value = $urandom;
    send_item(it);
  endtask

  // Let the block go quiet: every result in, then the load margin.
  task automatic wait_idle();
    @(negedge clk);
    req.valid = 1'b0;
    while (motion_q.size() != 0) @(negedge clk);
    repeat (LOAD_SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    wait_idle();
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == mjt_pkg::REG_DURATION) dur_reg = val[15:0];
    else cnt_reg = val[4:0];
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(200000)) - 100000);
      default: return $urandom;
    endcase
  endfunction

  // Result checker: compare each accepted beat with the oldest expectation.
  always @(posedge clk) begin
    motion_t got;
    motion_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      got = {rsp.axis, rsp.position, rsp.velocity, rsp.acceleration,
             rsp.segment, rsp.finished, rsp.last};
      if (motion_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result beat: axis %0d pos %h", got.axis, got.position);
      end else begin
        want = motion_q.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("result mismatch: exp axis %0d pos %h vel %h acc %h seg %0d fin %b last %b / got axis %0d pos %h vel %h acc %h seg %0d fin %b last %b",
                     want.axis, want.position, want.velocity, want.acceleration,
                     want.segment, want.finished, want.last,
                     got.axis, got.position, got.velocity, got.acceleration,
                     got.segment, got.finished, got.last);
        end
      end
    end
  end

  // Receiver back-pressure, changed at the falling edge.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every waypoint word gets a value before any tick reads it.
  task automatic test_fill();
    for (int w = 0; w < NWP; w++)
      for (int x = 0; x < NAX; x++) send_load(w, x, pick_value());
  endtask

  task automatic test_directed();
    write_reg(mjt_pkg::REG_DURATION, 32'd4);
    write_reg(mjt_pkg::REG_COUNT, 32'd3);
    // ignored writes: axis past the last one
    send_load(15, 7, 32'hFFFF_FFFF);
    send_load(0, 6, 32'h0);
    // time wraps while crossing the first segment
    now_ts = 32'hFFFF_FFFE;
    for (int k = 0; k <= 5; k++) send_tick(now_ts + 32'(k));
    send_tick(now_ts + 32'd6);
    for (int k = 0; k < 5; k++) send_tick(now_ts + 32'd7 + 32'(k * 3));
    send_tick(now_ts + 32'd40);
    send_tick(now_ts + 32'd41);
    // shortest segment with full-scale swing, sampled at its start, its end and past it
    write_reg(mjt_pkg::REG_DURATION, 32'd1);
    send_load(0, 0, 32'h8000_0000);
    send_load(1, 0, 32'h7FFF_FFFF);
    send_tick(32'd100);
    send_tick(32'd101);
    send_tick(32'd102);
    // zero duration and out-of-range waypoint counts
    write_reg(mjt_pkg::REG_DURATION, 32'd0);
    write_reg(mjt_pkg::REG_COUNT, 32'd0);
    send_tick(32'd7);
    send_load(3, 2, 32'h0001_0000);
    write_reg(mjt_pkg::REG_COUNT, 32'd31);
    send_tick(32'd0);
    send_tick(32'd1);
    send_tick(32'd3);
  endtask

  // Mostly in-order ticks marching through segments, some loads and wild times.
  task automatic test_random(input int num, input int unsigned dur, input int unsigned cnt);
    int unsigned d;
    int unsigned r;
    write_reg(mjt_pkg::REG_DURATION, dur);
    write_reg(mjt_pkg::REG_COUNT, cnt);
    d = (dur == 0) ? 1 : dur;
    now_ts = $urandom;
    for (int k = 0; k < num; k++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_load($urandom_range(15), $urandom_range(7), pick_value());
      end else if (r < 13) begin
        now_ts = $urandom;
        send_tick(now_ts);
      end else begin
        if (r < 25) now_ts += d + 1 + $urandom_range(3);
        else now_ts += $urandom_range(d / 4 + 1);
        send_tick(now_ts);
      end
      // sender holds off until the pipeline is empty
      if (k == num / 2) wait_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req.valid = 1'b0;
    req.op = mjt_pkg::OP_LOAD;
    req.time_stamp = '0;
    req.waypoint_number = '0;
    req.axis_number = '0;
    req.waypoint_value = '0;
    mismatch_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    seg_idx = 0;
    restart_pend = 1'b1;
    seg_t0 = '0;
    hold_done = 1'b0;
    dur_reg = mjt_pkg::DURATION_RESET;
    cnt_reg = mjt_pkg::COUNT_RESET;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_fill();
    test_directed();
    // no idling
    test_random(60, 65535, 16);
    test_random(20, 1, 2);
    // sender idle about half the time
    send_idle_pct = 51;
    test_random(60, 8, 16);
    // receiver stalling about half the time
    send_idle_pct = 0;
    recv_stall_pct = 51;
    test_random(60, 300, 5);
    // both, lightly
    send_idle_pct = 12;
    recv_stall_pct = 12;
    test_random(60, 20, 1);
    test_random(40, 3, 16);

    wait_idle();
    repeat (TICK_CYCLES) @(negedge clk);
    if (mismatch_cnt == 0 && motion_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run.
  initial begin
    #8000000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
rtl/mjt_pkg.sv
rtl/mjt_if.sv
rtl/mjt_store.sv
rtl/mjt_div.sv
rtl/mjt_cfg.sv
rtl/min_jerk_waypoint_trajectory_core.sv
dv/tb.sv
